FILE: sv/slsbs_pkg.sv
// Shared types and constants of the scan list strength sorter.
package slsbs_pkg;

  // Default number of cells in the insertion chain
  localparam int unsigned MAX_ENTRIES_DEF = 32;

  // One stored access-point entry
  typedef struct packed {
    logic signed [7:0] strength;
    logic [7:0]        mode;
    logic [7:0]        tag;
  } entry_t;

  // Per-cycle command broadcast along the chain
  typedef struct packed {
    logic ins;    // insert the arriving entry in sorted place
    logic shift;  // move every entry one cell towards the head
  } ctrl_t;

  // Controller state codes
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

endpackage

FILE: sv/slsbs_in_if.sv
// Handshake channel carrying one scanned entry per word.
interface slsbs_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] strength;
  logic [7:0]        mode;
  logic [7:0]        tag;
  logic              final_req;

  modport source (output valid, output strength, output mode, output tag,
                  output final_req, input ready);
  modport sink   (input valid, input strength, input mode, input tag,
                  input final_req, output ready);
endinterface

FILE: sv/slsbs_out_if.sv
// Handshake channel carrying one sorted entry per word.
interface slsbs_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] out_strength;
  logic [7:0]        out_mode;
  logic [7:0]        out_tag;
  logic              out_last;

  modport source (output valid, output out_strength, output out_mode,
                  output out_tag, output out_last, input ready);
  modport sink   (input valid, input out_strength, input out_mode,
                  input out_tag, input out_last, output ready);
endinterface

FILE: sv/scan_list_sort_by_strength_unit.sv
// Stable descending sort of a scanned access-point list: words load one per cycle into a chain of
// insertion cells, the chain staying sorted strongest first with equal strengths in arrival order.
// The word carrying final_req closes the list; after it the chain shifts its entries out towards
// the head, one result per cycle while the sink accepts, and input is held off until the last
// result has left the chain. Words beyond MAX_ENTRIES are dropped; a final word arriving on a full
// list still starts emission.
module scan_list_sort_by_strength_unit #(
  parameter int unsigned MAX_ENTRIES = slsbs_pkg::MAX_ENTRIES_DEF
) (
  input logic         clk,
  input logic         rst,
  slsbs_in_if.sink    scan,
  slsbs_out_if.source sorted
);
  import slsbs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             ovalid;
  logic             ovalid_next;
  entry_t           oentry;
  logic             olast;

  ctrl_t            ctrl;
  entry_t           new_entry;
  logic             accept;
  logic             full;
  logic             emit_load;
  entry_t           cells [MAX_ENTRIES];
  logic             keeps [MAX_ENTRIES];

  // Handshake and chain commands
  assign scan.ready = (state == ST_LOAD);
  assign accept     = scan.valid && scan.ready;
  assign full       = (count == CNT_W'(MAX_ENTRIES));
  assign emit_load  = (state == ST_EMIT) && (!ovalid || sorted.ready);
  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = emit_load;

  assign new_entry.strength = scan.strength;
  assign new_entry.mode     = scan.mode;
  assign new_entry.tag      = scan.tag;

  // Insertion chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    entry_t prev_e;
    entry_t next_e;
    logic   prev_k;

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_k = keeps[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_e = cells[i];
    end else begin : g_mid
      assign next_e = cells[i+1];
    end

    slsbs_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .occ        (IDX < count),
      .entry      (cells[i]),
      .keep       (keeps[i])
    );
  end

  // Controller next state
  always_comb begin
    state_next  = state;
    count_next  = count;
    ovalid_next = ovalid;
    unique case (state)
      ST_LOAD: begin
        if (ctrl.ins) begin
          count_next = count + CNT_W'(1);
        end
        if (accept && scan.final_req) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
    if (emit_load) begin
      ovalid_next = 1'b1;
    end else if (sorted.ready) begin
      ovalid_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ovalid <= ovalid_next;
    end
  end

  // Output register, fed from the head of the chain
  always_ff @(posedge clk) begin
    if (emit_load) begin
      oentry <= cells[0];
      olast  <= (count == CNT_W'(1));
    end
  end

  assign sorted.valid        = ovalid;
  assign sorted.out_strength = oentry.strength;
  assign sorted.out_mode     = oentry.mode;
  assign sorted.out_tag      = oentry.tag;
  assign sorted.out_last     = olast;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (count != '0))
    else $error("emitting from an empty chain");

  a_final_starts_emit: assert property (@(posedge clk) disable iff (rst)
    (accept && scan.final_req) |=> (state == ST_EMIT))
    else $error("final word did not start emission");

  a_last_ends_list: assert property (@(posedge clk) disable iff (rst)
    (emit_load && (count == CNT_W'(1))) |=> (state == ST_LOAD) && (count == '0))
    else $error("last result did not empty the chain");
`endif

endmodule

FILE: sv/slsbs_cell.sv
// One cell of the sorted insertion chain.
module slsbs_cell (
  input  logic             clk,
  input  slsbs_pkg::ctrl_t ctrl,
  input  slsbs_pkg::entry_t new_entry,
  input  slsbs_pkg::entry_t prev_entry,
  input  logic             prev_keep,
  input  slsbs_pkg::entry_t next_entry,
  input  logic             occ,
  output slsbs_pkg::entry_t entry,
  output logic             keep
);
  import slsbs_pkg::*;

  // An occupied entry stays put when it is at least as strong as the newcomer (stable)
  assign keep = occ && ($signed(entry.strength) >= $signed(new_entry.strength));

  // Insert: take newcomer at the boundary, neighbour's entry below it; shift: take the next cell's entry
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (prev_keep) begin
        if (!keep) begin
          entry <= new_entry;
        end
      end else begin
        entry <= prev_entry;
      end
    end else if (ctrl.shift) begin
      entry <= next_entry;
    end
  end

endmodule

FILE: dv/scan_list_sort_by_strength_unit_checker.sv
// Checker for the strength sorter: predicts each sorted run and compares every emitted word.
`timescale 1ns / 100ps

module scan_list_sort_by_strength_unit_checker #(
  parameter int unsigned DEPTH = slsbs_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  slsbs_in_if         scan,
  slsbs_out_if        sorted,
  output int unsigned failures,
  output int unsigned pending
);
  import slsbs_pkg::*;

  // one word of a sorted run as it should leave the block
  typedef struct packed {
    entry_t ent;
    logic   last;
  } ranked_word_t;

  entry_t       ranked_list[$];   // current list, strongest first, ties in arrival order
  ranked_word_t due_words[$];     // sorted words still to come out

  initial begin
    failures = 0;
    pending  = 0;
  end

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    failures++;
  endtask

  // place an entry after every stored one at least as strong; drop it when full
  task automatic place_by_strength(input entry_t e);
    int pos;
    pos = 0;
    if (ranked_list.size() >= DEPTH) return;
    while (pos < ranked_list.size() && ranked_list[pos].strength >= e.strength) pos++;
    ranked_list.insert(pos, e);
  endtask

  // closing word: the whole list becomes due, weakest entry flagged last
  task automatic close_list();
    ranked_word_t w;
    int n;
    n = ranked_list.size();
    for (int k = 0; k < n; k++) begin
      w.ent  = ranked_list[k];
      w.last = (k == n - 1);
      due_words.push_back(w);
    end
    ranked_list.delete();
  endtask

  always @(posedge clk) begin
    ranked_word_t w;
    entry_t       e;
    if (rst) begin
      ranked_list.delete();
      due_words.delete();
    end else begin
      // compare an accepted result word with the oldest one due
      if (sorted.valid && sorted.ready) begin
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word, tag", -1, sorted.out_tag);
        end else begin
          w = due_words.pop_front();
          if (sorted.out_strength !== w.ent.strength)
            report_mismatch("strength", w.ent.strength, sorted.out_strength);
          if (sorted.out_mode !== w.ent.mode)
            report_mismatch("mode", w.ent.mode, sorted.out_mode);
          if (sorted.out_tag !== w.ent.tag)
            report_mismatch("tag", w.ent.tag, sorted.out_tag);
          if (sorted.out_last !== w.last)
            report_mismatch("last", w.last, sorted.out_last);
        end
      end
      // predict from an accepted input word
      if (scan.valid && scan.ready) begin
        e.strength = scan.strength;
        e.mode     = scan.mode;
        e.tag      = scan.tag;
        place_by_strength(e);
        if (scan.final_req) close_list();
      end
    end
    pending <= due_words.size();
  end

endmodule

FILE: dv/scan_list_sort_by_strength_unit_tb.sv
// Testbench top for the strength sorter: drives scan lists, stalls the output, gives the verdict.
`timescale 1ns / 100ps

module scan_list_sort_by_strength_unit_tb;
  import slsbs_pkg::*;

  localparam int unsigned DEPTH       = MAX_ENTRIES_DEF;
  localparam int          HOLD_CYCLES = 300;
  localparam int          WORD_GOAL   = 250;

  logic clk = 1'b0;
  logic rst;

  int unsigned failures;
  int unsigned pending;

  bit quiet_src;      // sender offers back to back
  bit quiet_snk;      // receiver always ready
  int hold_req;       // bumped to ask the receiver for one long hold-off
  int words_sent;

  slsbs_in_if  scan ();
  slsbs_out_if sorted ();

  scan_list_sort_by_strength_unit #(.MAX_ENTRIES(DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan),
    .sorted (sorted)
  );

  scan_list_sort_by_strength_unit_checker #(.DEPTH(DEPTH)) chk (
    .clk      (clk),
    .rst      (rst),
    .scan     (scan),
    .sorted   (sorted),
    .failures (failures),
    .pending  (pending)
  );

  always #10 clk = ~clk;

  // safety net against a hung run
  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // strength mix: in range, forced ties, any 8-bit pattern
  function automatic logic signed [7:0] draw_strength();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 8'($urandom_range(256, 128));
    if (r < 85) begin
      case ($urandom_range(3, 0))
        0:       return -8'sd40;
        1:       return -8'sd41;
        2:       return 8'sd0;
        default: return -8'sd128;
      endcase
    end
    return 8'($urandom);
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input logic signed [7:0] s, input logic [7:0] m,
                           input logic [7:0] t, input logic fin);
    int gap;
    gap = quiet_src ? 0 : pick_gap();
    if (gap > 0) begin
      scan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan.valid     <= 1'b1;
    scan.strength  <= s;
    scan.mode      <= m;
    scan.tag       <= t;
    scan.final_req <= fin;
    @(posedge clk);
    while (!scan.ready) @(posedge clk);
    words_sent++;
  endtask

  // random list of len words, closed by the last one
  task automatic send_list(input int len);
    for (int k = 0; k < len; k++)
      send_word(draw_strength(), 8'($urandom), 8'($urandom), k == len - 1);
  endtask

  // stop offering and wait for every due word to come out
  task automatic drain();
    scan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // receiver: random ready gaps, plus a long hold-off on request
  initial begin : sink_side
    int gap;
    int hold_seen;
    hold_seen = 0;
    sorted.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        sorted.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = quiet_snk ? 0 : pick_gap();
        if (gap > 0) begin
          sorted.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        sorted.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int len;
    int lists;
    quiet_src  = 1'b1;
    quiet_snk  = 1'b1;
    hold_req   = 0;
    words_sent = 0;
    rst            <= 1'b1;
    scan.valid     <= 1'b0;
    scan.strength  <= '0;
    scan.mode      <= '0;
    scan.tag       <= '0;
    scan.final_req <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-entry list
    send_word(8'sd0, 8'hFF, 8'h00, 1'b1);
    // extremes, a positive strength, ties at zero, at the floor and in the middle
    send_word(-8'sd128, 8'h00, 8'hFF, 1'b0);
    send_word(8'sd0, 8'hFF, 8'h00, 1'b0);
    send_word(8'sd127, 8'h5A, 8'h01, 1'b0);
    send_word(-8'sd1, 8'hA5, 8'h02, 1'b0);
    send_word(-8'sd60, 8'h0F, 8'h0A, 1'b0);
    send_word(-8'sd60, 8'hF0, 8'h0B, 1'b0);
    send_word(8'sd0, 8'h33, 8'h0C, 1'b0);
    send_word(-8'sd128, 8'hCC, 8'h0D, 1'b0);
    send_word(8'sd1, 8'h80, 8'h0E, 1'b0);
    send_word(-8'sd60, 8'h7F, 8'h0F, 1'b1);
    // all equal strengths: arrival order must hold
    quiet_src = 1'b0;
    quiet_snk = 1'b0;
    send_word(-8'sd70, 8'h11, 8'h20, 1'b0);
    send_word(-8'sd70, 8'h22, 8'h21, 1'b0);
    send_word(-8'sd70, 8'h44, 8'h22, 1'b0);
    send_word(-8'sd70, 8'h88, 8'h23, 1'b1);
    drain();

    // overfill the store, the closing word dropped too, with the output held off
    quiet_src = 1'b1;
    hold_req++;
    send_list(DEPTH + 4);
    // next list is offered at once and must stall behind the held run
    send_list(5);
    quiet_src = 1'b0;
    drain();

    // random lists: mostly short, some around and beyond capacity
    lists = 0;
    while (words_sent < WORD_GOAL) begin
      quiet_src = ($urandom_range(3, 0) == 0);
      quiet_snk = ($urandom_range(3, 0) == 0);
      if ($urandom_range(9, 0) == 0) len = $urandom_range(DEPTH + 8, DEPTH - 4);
      else len = $urandom_range(12, 1);
      send_list(len);
      lists++;
      if (lists % 5 == 0) drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
